/* rtl/core/kpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpr_pkg
// Shared constants, codes and keymap helpers for the key matrix to
// character ring block.
// ----------------------------------------------------------------------------
package kpr_pkg;

    // ring geometry
    localparam int RING_DEPTH = 32;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int FILL_W     = 5;

    // key matrix geometry
    localparam int NUM_ROWS = 3;
    localparam int NUM_COLS = 3;
    localparam int NUM_KEYS = NUM_ROWS * NUM_COLS;
    localparam int KEY_W    = $clog2(NUM_KEYS);
    localparam int CHAR_W   = 8;
    localparam int SUB_W    = 2;

    // item operation codes
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // characters
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_LBR = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_DN  = 8'h42;

    // special keys
    localparam logic [KEY_W-1:0] KEY_CR      = KEY_W'(1);
    localparam logic [KEY_W-1:0] KEY_ESC     = KEY_W'(2);
    localparam logic [KEY_W-1:0] KEY_CUR_UP  = KEY_W'(5);
    localparam logic [KEY_W-1:0] KEY_CUR_DN  = KEY_W'(8);

    // character positions within a cursor sequence
    localparam logic [SUB_W-1:0] SEQ_FIRST = SUB_W'(0);
    localparam logic [SUB_W-1:0] SEQ_MID   = SUB_W'(1);
    localparam logic [SUB_W-1:0] SEQ_LAST  = SUB_W'(2);

    // true for keys that push a three character cursor sequence
    function automatic logic is_cursor_key(input logic [KEY_W-1:0] k);
        return (k == KEY_CUR_UP) || (k == KEY_CUR_DN);
    endfunction

    // character pushed for key k at sequence position sub
    function automatic logic [CHAR_W-1:0] key_char(input logic [KEY_W-1:0] k,
                                                   input logic [SUB_W-1:0] sub);
        logic [CHAR_W-1:0] ch;
        ch = CH_NUL;
        if (k == KEY_CR) begin
            ch = CH_CR;
        end else if (k == KEY_ESC) begin
            ch = CH_ESC;
        end else if (is_cursor_key(k)) begin
            case (sub)
                SEQ_FIRST: ch = CH_ESC;
                SEQ_MID:   ch = CH_LBR;
                default:   ch = (k == KEY_CUR_UP) ? CH_UP : CH_DN;
            endcase
        end
        return ch;
    endfunction

    // lowest pending key: column major, then row
    function automatic logic [KEY_W-1:0] first_key(input logic [NUM_KEYS-1:0] m);
        logic [KEY_W-1:0] k;
        logic             found;
        k     = '0;
        found = 1'b0;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (m[i] && !found) begin
                k     = KEY_W'(i);
                found = 1'b1;
            end
        end
        return k;
    endfunction

    // ring pointer advance with wrap
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

/* rtl/core/kpr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpr_if
// Valid/ready channels: scan or pop items in, status items out.
// ----------------------------------------------------------------------------
interface kpr_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [2:0] col0_keys;
    logic [2:0] col1_keys;
    logic [2:0] col2_keys;

    modport source (output valid, output op, output col0_keys, output col1_keys,
                    output col2_keys, input ready);
    modport sink   (input valid, input op, input col0_keys, input col1_keys,
                    input col2_keys, output ready);
endinterface

interface kpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       char_valid;
    logic [4:0] fill_count;
    logic       overflow;

    modport source (output valid, output char_out, output char_valid,
                    output fill_count, output overflow, input ready);
    modport sink   (input valid, input char_out, input char_valid,
                    input fill_count, input overflow, output ready);
endinterface

/* rtl/core/kpr_ring_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpr_ring_ram
// Simple dual port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kpr_ring_ram #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/kpr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpr_ctrl
// Sequencer: key edge detection, one ring push per cycle, pops through the
// RAM read port, and the registered status item toward the output channel.
// ----------------------------------------------------------------------------
module kpr_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    kpr_in_if.sink                              i_in,
    kpr_out_if.source                           o_out,
    output logic                                o_ram_we,
    output logic [kpr_pkg::PTR_W-1:0]           o_ram_waddr,
    output logic [kpr_pkg::CHAR_W-1:0]          o_ram_wdata,
    output logic                                o_ram_re,
    output logic [kpr_pkg::PTR_W-1:0]           o_ram_raddr,
    input  logic [kpr_pkg::CHAR_W-1:0]          i_ram_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_DONE
    } t_state;

    t_state                          r_state,     n_state;
    logic [kpr_pkg::NUM_KEYS-1:0]    r_prev,      n_prev;
    logic [kpr_pkg::NUM_KEYS-1:0]    r_pend,      n_pend;
    logic [kpr_pkg::SUB_W-1:0]       r_sub,       n_sub;
    logic [kpr_pkg::PTR_W-1:0]       r_wp,        n_wp;
    logic [kpr_pkg::PTR_W-1:0]       r_rp,        n_rp;
    logic [kpr_pkg::PTR_W-1:0]       r_held,      n_held;
    logic [kpr_pkg::CHAR_W-1:0]      r_res_char,  n_res_char;
    logic                            r_res_valid, n_res_valid;
    logic                            r_res_ovf,   n_res_ovf;
    logic                            r_out_valid, n_out_valid;
    logic [kpr_pkg::CHAR_W-1:0]      r_out_char,  n_out_char;
    logic                            r_out_cv,    n_out_cv;
    logic [kpr_pkg::FILL_W-1:0]      r_out_fill,  n_out_fill;
    logic                            r_out_ovf,   n_out_ovf;

    logic                            accept;
    logic                            out_free;
    logic                            ring_full;
    logic                            seq_last;
    logic [kpr_pkg::NUM_KEYS-1:0]    now_keys;
    logic [kpr_pkg::NUM_KEYS-1:0]    rise_keys;
    logic [kpr_pkg::NUM_KEYS-1:0]    pend_clr;
    logic [kpr_pkg::KEY_W-1:0]       cur_key;
    logic [kpr_pkg::CHAR_W-1:0]      cur_char;

    // handshake, held off during reset
    assign i_in.ready = i_rst_n && (r_state == S_IDLE);
    assign accept     = i_in.valid && i_rst_n && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;

    // key edge and push selection
    assign now_keys  = {i_in.col2_keys, i_in.col1_keys, i_in.col0_keys};
    assign rise_keys = now_keys & ~r_prev;
    assign cur_key   = kpr_pkg::first_key(r_pend);
    assign cur_char  = kpr_pkg::key_char(cur_key, r_sub);
    assign seq_last  = !kpr_pkg::is_cursor_key(cur_key) || (r_sub == kpr_pkg::SEQ_LAST);
    assign ring_full = (r_held == kpr_pkg::PTR_W'(kpr_pkg::RING_DEPTH - 1));

    always_comb begin
        pend_clr          = r_pend;
        pend_clr[cur_key] = 1'b0;
    end

    // ram ports
    assign o_ram_waddr = r_wp;
    assign o_ram_wdata = cur_char;
    assign o_ram_raddr = r_rp;
    assign o_ram_we    = (r_state == S_SCAN) && !ring_full;
    assign o_ram_re    = accept && (i_in.op == kpr_pkg::OP_POP) && (r_held != '0);

    // next state
    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_pend      = r_pend;
        n_sub       = r_sub;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_held      = r_held;
        n_res_char  = r_res_char;
        n_res_valid = r_res_valid;
        n_res_ovf   = r_res_ovf;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_cv    = r_out_cv;
        n_out_fill  = r_out_fill;
        n_out_ovf   = r_out_ovf;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_char  = kpr_pkg::CH_NUL;
                    n_res_valid = 1'b0;
                    n_res_ovf   = 1'b0;
                    if (i_in.op == kpr_pkg::OP_SCAN) begin
                        n_prev  = now_keys;
                        n_pend  = rise_keys;
                        n_sub   = kpr_pkg::SEQ_FIRST;
                        n_state = (rise_keys == '0) ? S_DONE : S_SCAN;
                    end else if (r_held != '0) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                // one push per cycle, dropped when the ring is full
                if (ring_full) begin
                    n_res_ovf = 1'b1;
                end else begin
                    n_wp   = kpr_pkg::ptr_inc(r_wp);
                    n_held = r_held + kpr_pkg::PTR_W'(1);
                end
                if (seq_last) begin
                    n_pend = pend_clr;
                    n_sub  = kpr_pkg::SEQ_FIRST;
                    if (pend_clr == '0) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_sub = r_sub + kpr_pkg::SUB_W'(1);
                end
            end
            S_READ: begin
                // read data arrives in the cycle after the address
                n_res_char  = i_ram_rdata;
                n_res_valid = 1'b1;
                n_rp        = kpr_pkg::ptr_inc(r_rp);
                n_held      = r_held - kpr_pkg::PTR_W'(1);
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_res_char;
                    n_out_cv    = r_res_valid;
                    n_out_fill  = kpr_pkg::FILL_W'(r_held);
                    n_out_ovf   = r_res_ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_res_char  <= n_res_char;
        r_res_valid <= n_res_valid;
        r_res_ovf   <= n_res_ovf;
        r_out_char  <= n_out_char;
        r_out_cv    <= n_out_cv;
        r_out_fill  <= n_out_fill;
        r_out_ovf   <= n_out_ovf;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_pend      <= '0;
            r_sub       <= kpr_pkg::SEQ_FIRST;
            r_wp        <= '0;
            r_rp        <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_pend      <= n_pend;
            r_sub       <= n_sub;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.char_out   = r_out_char;
    assign o_out.char_valid = r_out_cv;
    assign o_out.fill_count = r_out_fill;
    assign o_out.overflow   = r_out_ovf;

endmodule

/* rtl/core/keypad_edge_to_char_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_edge_to_char_ring
// 3x3 key matrix edge detector feeding a 32 entry character ring.
// ----------------------------------------------------------------------------
// Each input item is either a scan snapshot or a pop, and gives exactly one
// status item. Newly pressed keys are pushed into the ring one character per
// cycle through the single RAM write port, dropped characters included (keys
// 5 and 8 push three each). A pop steps through the address, the registered
// RAM read and the result; an empty pop skips the read.
// The ring holds up to 31 characters; a push into a full ring is dropped and
// flagged in overflow. A finished status item waits in the output register,
// and the next item is accepted as soon as the sequencer is idle again.
// ----------------------------------------------------------------------------
module keypad_edge_to_char_ring (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kpr_in_if.sink    i_in,
    kpr_out_if.source o_out
);

    logic                          ram_we;
    logic [kpr_pkg::PTR_W-1:0]     ram_waddr;
    logic [kpr_pkg::CHAR_W-1:0]    ram_wdata;
    logic                          ram_re;
    logic [kpr_pkg::PTR_W-1:0]     ram_raddr;
    logic [kpr_pkg::CHAR_W-1:0]    ram_rdata;

    // sequencer
    kpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // character ring storage
    kpr_ring_ram #(
        .DEPTH  (kpr_pkg::RING_DEPTH),
        .DATA_W (kpr_pkg::CHAR_W),
        .ADDR_W (kpr_pkg::PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
